[src/multi_stream_token_bucket_macros.svh]
`ifndef MULTI_STREAM_TOKEN_BUCKET_MACROS_SVH
`define MULTI_STREAM_TOKEN_BUCKET_MACROS_SVH

// Assertion sampled on the block clock and switched off while reset is held.
`define MSTB_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion sampled on the block clock that also holds during reset.
`define MSTB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/mstb_pkg.sv]
`timescale 1ns / 1ps
package mstb_pkg;

  // Defaults of the top level parameters.
  localparam int unsigned STREAMS_DEF = 4;
  localparam int unsigned SENDERS_DEF = 8;
  localparam int unsigned HOLDOFF_DEF = 1000;

  localparam int unsigned MAX_STREAMS = 4;

  // Field and register widths.
  localparam int unsigned TRATE_W   = 10;
  localparam int unsigned BMAX_W    = 15;
  localparam int unsigned SHARE_W   = 7;
  localparam int unsigned MASK_W    = 4;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ACT_W     = 3;
  localparam int unsigned SEL_W     = 2;
  localparam int unsigned COST_W    = 8;
  localparam int unsigned PTR_W     = 3;
  localparam int unsigned BAL_W     = 16;
  localparam int unsigned HOLD_W    = 10;

  // Rate arithmetic. A percent share of the total is at most 127 * 1023 / 100,
  // the redistributed total at most 1023 + 4 * 1299 and a stream rate at most
  // 127 * 6219 / 100.
  localparam int unsigned PERCENT = 100;
  localparam int unsigned PROD_W  = SHARE_W + TRATE_W;
  localparam int unsigned PART_W  = 11;
  localparam int unsigned AVAIL_W = 13;
  localparam int unsigned MIX_W   = SHARE_W + AVAIL_W;
  localparam int unsigned RATE_W  = 13;

  // Division by one hundred as a multiplication by a rounded-up reciprocal.
  // Both shifts are chosen so that the quotient is exact over the whole range.
  localparam int unsigned RECIP1_SH = 24;
  localparam int unsigned RECIP1    = (2 ** RECIP1_SH + PERCENT - 1) / PERCENT;
  localparam int unsigned RECIP1_W  = 18;
  localparam int unsigned DIV1_W    = PROD_W + RECIP1_W;
  localparam int unsigned RECIP2_SH = 27;
  localparam int unsigned RECIP2    = (2 ** RECIP2_SH + PERCENT - 1) / PERCENT;
  localparam int unsigned RECIP2_W  = 21;
  localparam int unsigned DIV2_W    = MIX_W + RECIP2_W;

  // Register stages from the configuration registers to the stream rates.
  localparam int unsigned RATE_LAT = 5;
  localparam int unsigned SETTLE_W = 3;

  localparam int unsigned QUEUE_DEPTH = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_0    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_1    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_2    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_3    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd6;

  // Action codes of the input transaction.
  localparam logic [ACT_W-1:0] ACT_TICK          = 3'd0;
  localparam logic [ACT_W-1:0] ACT_QUERY         = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CHARGE_NOTE   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CHARGE_SENDER = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FAILURE       = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_QUERY,
    OP_CHARGE_NOTE,
    OP_CHARGE_SENDER,
    OP_FAILURE
  } op_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [SEL_W-1:0]  stream_sel;
    logic [COST_W-1:0] cost;
  } in_t;

  typedef struct packed {
    logic                    allowed;
    logic [PTR_W-1:0]        sender_index;
    logic signed [BAL_W-1:0] balance;
    logic                    suspended;
  } out_t;

  typedef struct packed {
    logic [TRATE_W-1:0]                    total_rate;
    logic [BMAX_W-1:0]                     bucket_max;
    logic [MAX_STREAMS-1:0][SHARE_W-1:0]   share;
    logic [MASK_W-1:0]                     enable;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic              sel_ok;
    logic [SEL_W-1:0]  sel;
    logic [COST_W-1:0] cost;
  } cmd_t;

  typedef logic [RATE_W-1:0] rate_t;

endpackage

[src/mstb_front.sv]
`timescale 1ns / 1ps
module mstb_front #(
  parameter int unsigned STREAMS = mstb_pkg::STREAMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mstb_pkg::in_t                    in_data_i,
  input  logic                             cfg_we_i,
  input  logic [mstb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mstb_pkg::CFG_W-1:0]       cfg_wdata_i,
  output mstb_pkg::cfg_t                   cfg_o,
  output logic                             cfg_wr_o,
  output logic                             push_o,
  output mstb_pkg::cmd_t                   push_cmd_o,
  input  logic                             full_i
);
  import mstb_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TOTAL_RATE: cfg_q.total_rate <= cfg_wdata_i[TRATE_W-1:0];
        REG_BUCKET_MAX: cfg_q.bucket_max <= cfg_wdata_i[BMAX_W-1:0];
        REG_SHARE_0:    cfg_q.share[0]   <= cfg_wdata_i[SHARE_W-1:0];
        REG_SHARE_1:    cfg_q.share[1]   <= cfg_wdata_i[SHARE_W-1:0];
        REG_SHARE_2:    cfg_q.share[2]   <= cfg_wdata_i[SHARE_W-1:0];
        REG_SHARE_3:    cfg_q.share[3]   <= cfg_wdata_i[SHARE_W-1:0];
        REG_ENABLE:     cfg_q.enable     <= cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o    = cfg_q;
  assign cfg_wr_o = cfg_we_i;

  // Unused action codes behave like a query.
  always_comb begin
    push_cmd_o.sel    = in_data_i.stream_sel;
    push_cmd_o.cost   = in_data_i.cost;
    push_cmd_o.sel_ok = (32'(in_data_i.stream_sel) < STREAMS);
    case (in_data_i.action)
      ACT_TICK:          push_cmd_o.op = OP_TICK;
      ACT_QUERY:         push_cmd_o.op = OP_QUERY;
      ACT_CHARGE_NOTE:   push_cmd_o.op = OP_CHARGE_NOTE;
      ACT_CHARGE_SENDER: push_cmd_o.op = OP_CHARGE_SENDER;
      ACT_FAILURE:       push_cmd_o.op = OP_FAILURE;
      default:           push_cmd_o.op = OP_QUERY;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

[src/mstb_fifo.sv]
`timescale 1ns / 1ps
module mstb_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mstb_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  output logic           valid_o,
  output mstb_pkg::cmd_t head_o,
  input  logic           pop_i
);
  import mstb_pkg::*;

  localparam int unsigned PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                mem_q [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] count_q;

  function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
    next_ptr = (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  assign full_o  = (count_q == CNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

[src/mstb_rate.sv]
`timescale 1ns / 1ps
module mstb_rate #(
  parameter int unsigned STREAMS = mstb_pkg::STREAMS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mstb_pkg::cfg_t                cfg_i,
  input  logic                          cfg_wr_i,
  output mstb_pkg::rate_t [STREAMS-1:0] rate_o,
  output logic                          ready_o
);
  import mstb_pkg::*;

  logic [STREAMS-1:0][PROD_W-1:0] prod_q;
  logic [STREAMS-1:0][PART_W-1:0] part_q;
  logic [AVAIL_W-1:0]             avail_q, avail_d;
  logic [STREAMS-1:0][MIX_W-1:0]  mix_q;
  rate_t [STREAMS-1:0]            rate_q;
  logic [STREAMS-1:0][DIV1_W-1:0] quot1;
  logic [STREAMS-1:0][DIV2_W-1:0] quot2;
  logic [SETTLE_W-1:0]            settle_q;

  always_comb begin
    avail_d = AVAIL_W'(cfg_i.total_rate);
    for (int j = 0; j < STREAMS; j++) begin
      quot1[j] = (DIV1_W'(prod_q[j]) * DIV1_W'(RECIP1)) >> RECIP1_SH;
      quot2[j] = (DIV2_W'(mix_q[j]) * DIV2_W'(RECIP2)) >> RECIP2_SH;
      if (!cfg_i.enable[j]) begin
        avail_d = avail_d + AVAIL_W'(part_q[j]);
      end
    end
  end

  // Share product, percent of it, redistributed total, share of that total,
  // percent of that: one register after each step.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < STREAMS; j++) begin
      prod_q[j] <= PROD_W'(cfg_i.share[j]) * PROD_W'(cfg_i.total_rate);
      part_q[j] <= quot1[j][PART_W-1:0];
      mix_q[j]  <= MIX_W'(cfg_i.share[j]) * MIX_W'(avail_q);
      rate_q[j] <= cfg_i.enable[j] ? quot2[j][RATE_W-1:0] : '0;
    end
    avail_q <= avail_d;
  end

  // The rates are trusted once every stage has seen the current registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_W'(RATE_LAT);
    end else if (cfg_wr_i) begin
      settle_q <= SETTLE_W'(RATE_LAT);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign rate_o  = rate_q;
  assign ready_o = (settle_q == '0);

endmodule

[src/mstb_back.sv]
`timescale 1ns / 1ps
module mstb_back #(
  parameter int unsigned STREAMS       = mstb_pkg::STREAMS_DEF,
  parameter int unsigned SENDERS       = mstb_pkg::SENDERS_DEF,
  parameter int unsigned HOLDOFF_TICKS = mstb_pkg::HOLDOFF_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mstb_pkg::cfg_t                cfg_i,
  input  mstb_pkg::rate_t [STREAMS-1:0] rate_i,
  input  logic                          rate_ready_i,
  input  logic                          cmd_valid_i,
  input  mstb_pkg::cmd_t                cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mstb_pkg::out_t                out_data_o
);
  import mstb_pkg::*;

  logic signed [BAL_W-1:0] bucket_q [STREAMS];
  logic signed [BAL_W-1:0] bucket_d [STREAMS];
  logic [PTR_W-1:0]        ptr_q [STREAMS];
  logic [PTR_W-1:0]        ptr_d [STREAMS];
  logic [HOLD_W-1:0]       hold_q, hold_d;
  logic                    out_valid_q;
  out_t                    out_q, out_d;
  logic [STREAMS-1:0]      hit;
  logic                    take;

  assign take  = cmd_valid_i && rate_ready_i && (!out_valid_q || !out_stall_i);
  assign pop_o = take;

  always_comb begin
    logic signed [BAL_W:0]   sum;
    logic signed [BAL_W:0]   lim;
    logic signed [BAL_W-1:0] sel_bal;
    logic [PTR_W-1:0]        sel_ptr;
    hold_d   = hold_q;
    bucket_d = bucket_q;
    ptr_d    = ptr_q;
    sel_bal  = '0;
    sel_ptr  = '0;
    sum      = '0;
    lim      = $signed({2'b00, cfg_i.bucket_max});
    for (int i = 0; i < STREAMS; i++) begin
      hit[i] = cmd_i.sel_ok && (cmd_i.sel == SEL_W'(i));
    end

    case (cmd_i.op)
      OP_TICK: begin
        if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
        end else begin
          for (int i = 0; i < STREAMS; i++) begin
            if (cfg_i.total_rate == '0) begin
              bucket_d[i] = '0;
            end else if (cfg_i.enable[i]
                         && ($signed({bucket_q[i][BAL_W-1], bucket_q[i]}) < lim)) begin
              sum = $signed({bucket_q[i][BAL_W-1], bucket_q[i]})
                  + $signed((BAL_W + 1)'(rate_i[i]));
              bucket_d[i] = (sum > lim) ? lim[BAL_W-1:0] : sum[BAL_W-1:0];
            end
          end
        end
      end
      OP_FAILURE: begin
        hold_d = HOLD_W'(HOLDOFF_TICKS);
      end
      default: begin
        if (cmd_i.op inside {OP_CHARGE_NOTE, OP_CHARGE_SENDER}) begin
          for (int i = 0; i < STREAMS; i++) begin
            if (hit[i]) begin
              sum = $signed({bucket_q[i][BAL_W-1], bucket_q[i]})
                  - $signed((BAL_W + 1)'(cmd_i.cost));
              // Only the negative side can leave the 16-bit range.
              if (sum[BAL_W] != sum[BAL_W-1]) begin
                bucket_d[i] = {1'b1, {(BAL_W - 1){1'b0}}};
              end else begin
                bucket_d[i] = sum[BAL_W-1:0];
              end
              if (cmd_i.op == OP_CHARGE_SENDER) begin
                ptr_d[i] = (ptr_q[i] == PTR_W'(SENDERS - 1)) ? '0 : ptr_q[i] + 1'b1;
              end
            end
          end
        end
      end
    endcase

    for (int i = 0; i < STREAMS; i++) begin
      if (hit[i]) begin
        sel_bal = bucket_d[i];
        sel_ptr = ptr_d[i];
      end
    end
    out_d.allowed      = (cfg_i.total_rate == '0) || (sel_bal > 16'sd0);
    out_d.sender_index = sel_ptr;
    out_d.balance      = sel_bal;
    out_d.suspended    = (hold_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STREAMS; i++) begin
        bucket_q[i] <= '0;
        ptr_q[i]    <= '0;
      end
      hold_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        bucket_q    <= bucket_d;
        ptr_q       <= ptr_d;
        hold_q      <= hold_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/multi_stream_token_bucket.sv]
`timescale 1ns / 1ps
// Token bucket rate limiter with one signed balance and one round-robin sender
// pointer per stream.
// Input channel (in_valid_i, in_stall_o, in_data_i) carries one transaction per
// event: tick, query, charge note, charge sender or failure. Every transaction
// gives exactly one result transaction on the output channel (out_valid_o,
// out_stall_i, out_data_o) about the stream it selects, in input order.
// Throughput is one transaction per cycle unless the receiver stalls or the
// rates are not ready; queue entry and result are registered. A two-entry queue
// separates the decoding front from the bucket update, so either side may stall.
// Stream rates come from a five-stage pipeline fed by the registers; after
// reset and each register write, queued transactions wait until it settles
// before the bucket update takes them. The user must write registers on the
// plain port (cfg_we_i, cfg_idx_i, cfg_wdata_i) only while no transaction is
// in flight; the block does not enforce it. Reset clears every register,
// balance, pointer and the hold-off counter. While the receiver stalls the
// result is held, the queue fills and in_stall_o rises once it is full.
module multi_stream_token_bucket #(
  parameter int unsigned STREAMS       = mstb_pkg::STREAMS_DEF,
  parameter int unsigned SENDERS       = mstb_pkg::SENDERS_DEF,
  parameter int unsigned HOLDOFF_TICKS = mstb_pkg::HOLDOFF_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mstb_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mstb_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [mstb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mstb_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import mstb_pkg::*;

  cfg_t                cfg;
  logic                cfg_wr;
  logic                push, full, cmd_valid, pop, rate_ready;
  cmd_t                push_cmd, head_cmd;
  rate_t [STREAMS-1:0] rate;

  mstb_front #(
    .STREAMS(STREAMS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg),
    .cfg_wr_o   (cfg_wr),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .full_i     (full)
  );

  mstb_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .valid_o   (cmd_valid),
    .head_o    (head_cmd),
    .pop_i     (pop)
  );

  mstb_rate #(
    .STREAMS(STREAMS)
  ) u_rate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cfg_wr_i(cfg_wr),
    .rate_o  (rate),
    .ready_o (rate_ready)
  );

  mstb_back #(
    .STREAMS      (STREAMS),
    .SENDERS      (SENDERS),
    .HOLDOFF_TICKS(HOLDOFF_TICKS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .rate_i      (rate),
    .rate_ready_i(rate_ready),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[src/mstb_checker.sv]
`timescale 1ns / 1ps
`include "multi_stream_token_bucket_macros.svh"
module mstb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input mstb_pkg::out_t out_data_o
);
  import mstb_pkg::*;

  // A stalled result transaction stays offered and unchanged.
  `MSTB_ASSERT_CLK(a_out_valid_holds, out_valid_o && out_stall_i |=> out_valid_o, "result dropped")
  `MSTB_ASSERT_CLK(a_out_data_holds, out_valid_o && out_stall_i |=> $stable(out_data_o), "result changed")

  // No result is offered while reset is held.
  `MSTB_ASSERT_RST(a_reset_idle, !rst_ni |-> !out_valid_o, "result during reset")

  // A positive balance always permits sending.
  `MSTB_ASSERT_CLK(a_allowed_balance, out_valid_o && (out_data_o.balance > 16'sd0) |-> out_data_o.allowed, "positive balance not allowed")

endmodule

bind multi_stream_token_bucket mstb_checker u_mstb_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import mstb_pkg::*;

  localparam int unsigned N_STREAMS   = STREAMS_DEF;
  localparam int unsigned N_SENDERS   = SENDERS_DEF;
  localparam int unsigned HOLDOFF     = HOLDOFF_DEF;
  localparam int          BAL_FLOOR   = -32768;
  localparam int unsigned IDLE_PCT    = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Action codes the block does not define; it must treat them as queries.
  localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;

  // Shadow of the rate limiter: registers, balances, pointers and hold-off.
  cfg_t rl_cfg = '0;
  int balance_q[N_STREAMS];
  logic [PTR_W-1:0] sender_q[N_STREAMS];
  logic [HOLD_W-1:0] holdoff_left = '0;

  in_t pending_q[$];
  out_t expected_q[$];
  int unsigned queued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned settings_count = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit item_taken = 1'b0;
  bit calm = 1'b0;

  multi_stream_token_bucket dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic out_t predict_bucket_step(in_t txn);
    out_t res;
    int unsigned s;
    int unsigned pool;
    int unsigned rate;
    int level;
    s = txn.stream_sel;
    case (txn.action)
      ACT_TICK: begin
        if (holdoff_left != 0) begin
          holdoff_left = holdoff_left - 1'b1;
        end else begin
          for (int i = 0; i < N_STREAMS; i++) begin
            if (rl_cfg.total_rate == 0) begin
              balance_q[i] = 0;
            end else if (rl_cfg.enable[i] && balance_q[i] < int'(rl_cfg.bucket_max)) begin
              // Shares of disabled streams are folded back into the pool first.
              pool = rl_cfg.total_rate;
              for (int j = 0; j < N_STREAMS; j++) begin
                if (!rl_cfg.enable[j]) begin
                  pool += int'(rl_cfg.share[j]) * int'(rl_cfg.total_rate) / PERCENT;
                end
              end
              rate = int'(rl_cfg.share[i]) * pool / PERCENT;
              level = balance_q[i] + int'(rate);
              balance_q[i] = (level > int'(rl_cfg.bucket_max)) ? int'(rl_cfg.bucket_max) : level;
            end
          end
        end
      end
      ACT_FAILURE: holdoff_left = HOLD_W'(HOLDOFF);
      ACT_CHARGE_NOTE, ACT_CHARGE_SENDER: begin
        level = balance_q[s] - int'(txn.cost);
        balance_q[s] = (level < BAL_FLOOR) ? BAL_FLOOR : level;
        if (txn.action == ACT_CHARGE_SENDER) begin
          sender_q[s] = PTR_W'((int'(sender_q[s]) + 1) % N_SENDERS);
        end
      end
      default: ;
    endcase
    res.allowed      = (rl_cfg.total_rate == 0) || (balance_q[s] > 0);
    res.sender_index = sender_q[s];
    res.balance      = BAL_W'(balance_q[s]);
    res.suspended    = (holdoff_left != 0);
    return res;
  endfunction

  // Sender and receiver both change their signals on the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      out_stall_i <= 1'b0;
    end else begin
      if (!in_valid_i || item_taken) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_data_i  <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $error("result with no transaction outstanding: %p", out_data_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          checked_total++;
          if (out_data_o.allowed !== want.allowed) begin
            $error("allowed: expected %0d, got %0d", want.allowed, out_data_o.allowed);
            mismatches++;
          end
          if (out_data_o.sender_index !== want.sender_index) begin
            $error("sender_index: expected %0d, got %0d", want.sender_index,
                   out_data_o.sender_index);
            mismatches++;
          end
          if (out_data_o.balance !== want.balance) begin
            $error("balance: expected %0d, got %0d", $signed(want.balance),
                   $signed(out_data_o.balance));
            mismatches++;
          end
          if (out_data_o.suspended !== want.suspended) begin
            $error("suspended: expected %0d, got %0d", want.suspended,
                   out_data_o.suspended);
            mismatches++;
          end
        end
      end
      item_taken = rst_ni && in_valid_i && !in_stall_o;
      if (item_taken) begin
        expected_q.push_back(predict_bucket_step(in_data_i));
        accepted_total++;
      end
    end
  end

  task automatic push_item(logic [ACT_W-1:0] act, int unsigned sel, int unsigned cost);
    in_t txn;
    txn.action     = act;
    txn.stream_sel = SEL_W'(sel);
    txn.cost       = COST_W'(cost);
    pending_q.push_back(txn);
    queued_total++;
  endtask

  // Weights are percentages; whatever is left over becomes queries.
  task automatic queue_random(int unsigned n, int unsigned tick_w, int unsigned note_w,
                              int unsigned sender_w, int unsigned fail_w,
                              int unsigned spare_w, int unsigned favour0,
                              int unsigned cost_floor);
    int unsigned roll;
    int unsigned sel;
    logic [ACT_W-1:0] act;
    repeat (n) begin
      roll = $urandom_range(99);
      if (roll < tick_w) act = ACT_TICK;
      else if (roll < tick_w + note_w) act = ACT_CHARGE_NOTE;
      else if (roll < tick_w + note_w + sender_w) act = ACT_CHARGE_SENDER;
      else if (roll < tick_w + note_w + sender_w + fail_w) act = ACT_FAILURE;
      else if (roll < tick_w + note_w + sender_w + fail_w + spare_w)
        act = ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      else act = ACT_QUERY;
      sel = ($urandom_range(99) < favour0) ? 0 : $urandom_range(N_STREAMS - 1);
      push_item(act, sel, $urandom_range(255, cost_floor));
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (accepted_total != queued_total || expected_q.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    case (idx)
      REG_TOTAL_RATE: rl_cfg.total_rate = TRATE_W'(val);
      REG_BUCKET_MAX: rl_cfg.bucket_max = BMAX_W'(val);
      REG_SHARE_0:    rl_cfg.share[0] = SHARE_W'(val);
      REG_SHARE_1:    rl_cfg.share[1] = SHARE_W'(val);
      REG_SHARE_2:    rl_cfg.share[2] = SHARE_W'(val);
      REG_SHARE_3:    rl_cfg.share[3] = SHARE_W'(val);
      REG_ENABLE:     rl_cfg.enable = MASK_W'(val);
      default: ;
    endcase
  endtask

  // The sender holds back until every result is in before the registers change.
  task automatic apply_config(int unsigned total, int unsigned bmax, int unsigned s0,
                              int unsigned s1, int unsigned s2, int unsigned s3,
                              int unsigned mask);
    drain();
    repeat (RATE_LAT + 2) @(negedge clk_i);
    write_reg(REG_TOTAL_RATE, total);
    write_reg(REG_BUCKET_MAX, bmax);
    write_reg(REG_SHARE_0, s0);
    write_reg(REG_SHARE_1, s1);
    write_reg(REG_SHARE_2, s2);
    write_reg(REG_SHARE_3, s3);
    write_reg(REG_ENABLE, mask);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_count++;
  endtask

  initial begin
    rst_ni <= 1'b0;
    for (int i = 0; i < N_STREAMS; i++) begin
      balance_q[i] = 0;
      sender_q[i]  = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Registers at reset: limiting is off, so everything is allowed.
    push_item(ACT_QUERY, 0, 0);
    push_item(ACT_TICK, 1, 255);
    push_item(ACT_CHARGE_NOTE, 1, 255);
    push_item(ACT_CHARGE_SENDER, 2, 0);
    push_item(ACT_SPARE_LAST, 3, 128);

    apply_config(1023, 32767, 127, 100, 0, 55, 4'b1011);
    push_item(ACT_TICK, 0, 0);
    push_item(ACT_TICK, 3, 255);
    for (int s = 0; s < N_STREAMS; s++) push_item(ACT_QUERY, s, 0);
    push_item(ACT_CHARGE_NOTE, 0, 255);
    push_item(ACT_CHARGE_NOTE, 3, 0);
    push_item(ACT_CHARGE_SENDER, 1, 255);
    push_item(ACT_SPARE_FIRST, 2, 1);
    push_item(ACT_W'(ACT_SPARE_FIRST + 1), 1, 170);

    apply_config($urandom_range(1023, 1), $urandom_range(3000, 100), $urandom_range(127),
                 $urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(15));
    queue_random(260, 35, 20, 20, 0, 5, 0, 0);

    // No refill at all, and heavy charges on stream 0 drive it to the floor.
    apply_config(1, 0, 0, 0, 0, 0, 0);
    calm = 1'b1;
    queue_random(220, 5, 45, 45, 0, 0, 90, 200);
    drain();
    calm = 1'b0;

    apply_config(0, $urandom_range(32767), $urandom_range(127), $urandom_range(127),
                 $urandom_range(127), $urandom_range(127), $urandom_range(15));
    queue_random(100, 35, 20, 20, 0, 5, 0, 0);
    apply_config($urandom_range(1023, 1), $urandom_range(60), $urandom_range(127),
                 $urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(15));
    queue_random(100, 35, 20, 20, 0, 5, 0, 0);
    apply_config($urandom_range(1023, 1), $urandom_range(32767), $urandom_range(127),
                 $urandom_range(127), $urandom_range(127), $urandom_range(127),
                 $urandom_range(15));
    queue_random(100, 35, 20, 20, 0, 5, 0, 0);
    // Three disabled streams at the largest share give the biggest redistribution.
    apply_config(1023, 32767, 127, 127, 127, 127, 4'b0001);
    queue_random(100, 35, 20, 20, 3, 5, 0, 0);

    // Hold-off: a failure, ticks while suspended, a reload, then more of the countdown.
    apply_config(500, 4000, 40, 30, 20, 10, 4'b0111);
    push_item(ACT_FAILURE, 0, 0);
    push_item(ACT_TICK, 1, 0);
    push_item(ACT_TICK, 2, 255);
    push_item(ACT_FAILURE, 3, 255);
    push_item(ACT_QUERY, 0, 0);
    repeat (100) push_item(ACT_TICK, $urandom_range(N_STREAMS - 1), $urandom_range(255));
    queue_random(40, 40, 20, 20, 0, 5, 0, 0);

    drain();
    repeat (RATE_LAT + 4) @(negedge clk_i);
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      mismatches++;
    end
    $display("Checked %0d results of %0d transactions under %0d register settings.",
             checked_total, accepted_total, settings_count);
    $display("Run covered refill limits, balance floor, pointer wrap and hold-off reloads.");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[multi_stream_token_bucket.f]
+incdir+src
src/mstb_pkg.sv
src/mstb_front.sv
src/mstb_fifo.sv
src/mstb_rate.sv
src/mstb_back.sv
src/multi_stream_token_bucket.sv
src/mstb_checker.sv
verif/testbench.sv
